>>> hdl/srdd_pkg.sv
// Shared types and constants for the speed ramp / differential drive block.
// Holds the microcode word layout, opcode codes and fixed arithmetic constants.
// No dependencies.
`default_nettype none

package srdd_pkg;

    // microcode program counter
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // multiplier operand pair launched by a step
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE     = 3'd0;
    localparam mul_sel_t MUL_LIN_FAC  = 3'd1;
    localparam mul_sel_t MUL_V_K      = 3'd2;
    localparam mul_sel_t MUL_ANG_HW   = 3'd3;
    localparam mul_sel_t MUL_MAG_GAIN = 3'd4;
    localparam mul_sel_t MUL_X_RECIP  = 3'd5;
    localparam mul_sel_t MUL_Q_K      = 3'd6;

    // datapath operation of a step, most of them on the registered product
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP  = 4'd0;
    localparam op_t OP_TGT  = 4'd1;
    localparam op_t OP_RAMP = 4'd2;
    localparam op_t OP_VK   = 4'd3;
    localparam op_t OP_AH   = 4'd4;
    localparam op_t OP_SIDE = 4'd5;
    localparam op_t OP_X    = 4'd6;
    localparam op_t OP_QE   = 4'd7;
    localparam op_t OP_FIX  = 4'd8;

    typedef logic cond_t;
    localparam cond_t COND_NEXT  = 1'b0;
    localparam cond_t COND_SIDE0 = 1'b1;

    typedef struct packed {
        mul_sel_t mul;
        op_t      op;
        cond_t    cond;
        pc_t      target;
        logic     last;
    } uword_t;

    typedef struct packed {
        logic side;     // 0 = left wheel pass, 1 = right wheel pass
    } dp_status_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_RAMP_ENABLE = 3'd0;
    localparam cfg_index_t REG_ACCEL_STEP  = 3'd1;
    localparam cfg_index_t REG_DECEL_STEP  = 3'd2;
    localparam cfg_index_t REG_HALF_WB     = 3'd3;
    localparam cfg_index_t REG_RPM_GAIN    = 3'd4;
    localparam cfg_index_t REG_RAMP_PERIOD = 3'd5;

    localparam logic        RST_RAMP_ENABLE = 1'b1;
    localparam logic [9:0]  RST_ACCEL_STEP  = 10'd20;
    localparam logic [9:0]  RST_DECEL_STEP  = 10'd20;
    localparam logic [9:0]  RST_HALF_WB     = 10'd180;
    localparam logic [17:0] RST_RPM_GAIN    = 18'd80105;
    localparam logic [7:0]  RST_RAMP_PERIOD = 8'd20;

    // shared multiplier: signed A times unsigned B
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    localparam logic [MUL_B_W-1:0] K_MILLI   = 23'd1000;
    localparam logic [MUL_B_W-1:0] K_RECIP   = 23'd4294967;  // floor(2^32 / 1000)
    localparam logic [28:0]        K_THOUS29 = 29'd1000;
    localparam logic [44:0]        RPM_HALF  = 45'd32768000; // half of 1000 * 65536
    localparam logic [27:0]        TGT_HALF  = 28'd8192;

    localparam logic signed [13:0] SPEED_MAX = 14'sd8191;
    localparam logic signed [13:0] SPEED_MIN = -14'sd8192;
    localparam logic signed [18:0] RPM_MAX   = 19'sd262143;
    localparam logic signed [18:0] RPM_MIN   = -19'sd262144;

endpackage

`default_nettype wire

>>> hdl/speed_ramp_diff_drive_rpm.sv
// Top level of the speed ramp and differential drive wheel rpm block.
// Depends on srdd_pkg, srdd_ucode_rom, srdd_sequencer and srdd_datapath.
`default_nettype none

// One request gives one result. After a request is accepted the microcode
// runs the target, ramp and left wheel steps, the same loop again for the
// right wheel and one step to hand over the result; no new request is taken
// before it ends. The pace is set by the single shared multiplier: every
// product, including the reciprocal divide by 1000, goes through it one step
// at a time. A finished result waits in an output register, and the next
// request may start while it waits; the program only holds on its last step
// if the previous result has not been taken yet.

module speed_ramp_diff_drive_rpm
    import srdd_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    // configuration
    input  wire                     cfg_we,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data,
    // request stream
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // now_ms[31:0], linear_target[44:32], angular_target[60:45],
    // speed_factor[75:61], zero pad [79:76]
    input  wire [79:0]              s_axis_tdata,
    // use_ramp[0]
    input  wire [0:0]               s_axis_tuser,
    // result stream
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // ramped_speed[13:0], left_rpm[32:14], right_rpm[51:33], zero pad [55:52]
    output logic [55:0]             m_axis_tdata
);

    pc_t                pc;
    logic               busy;
    logic               start;
    logic               stall;
    uword_t             uword;
    dp_status_t         status;
    logic signed [13:0] speed;
    logic signed [18:0] left_rpm;
    logic signed [18:0] right_rpm;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [51:0]        out_data_reg;
    logic               finish;

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;
    assign stall         = uword.last && out_valid_reg && !m_axis_tready;
    assign finish        = busy && uword.last && !stall;

    srdd_ucode_rom u_rom
    (
        .pc    (pc),
        .uword (uword)
    );

    srdd_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stall  (stall),
        .uword  (uword),
        .status (status),
        .pc     (pc),
        .busy   (busy)
    );

    srdd_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .load           (start),
        .now_ms         (s_axis_tdata[31:0]),
        .linear_target  ($signed(s_axis_tdata[44:32])),
        .angular_target ($signed(s_axis_tdata[60:45])),
        .use_ramp       (s_axis_tuser[0]),
        .speed_factor   (s_axis_tdata[75:61]),
        .uword          (uword),
        .status         (status),
        .ramped_speed   (speed),
        .left_rpm       (left_rpm),
        .right_rpm      (right_rpm)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
            out_data_reg <= {right_rpm, left_rpm, speed};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule

`default_nettype wire

>>> hdl/srdd_ucode_rom.sv
// Microcode program store: one control word per step.
// Depends on srdd_pkg.
`default_nettype none

module srdd_ucode_rom
    import srdd_pkg::*;
(
    input  wire pc_t    pc,
    output uword_t      uword
);

    always_comb
    begin
        unique case (pc)
            // scaled target
            4'd0:    uword = '{MUL_LIN_FAC,  OP_NOP,  COND_NEXT,  4'd0, 1'b0};
            4'd1:    uword = '{MUL_NONE,     OP_TGT,  COND_NEXT,  4'd0, 1'b0};
            // ramp step or direct take
            4'd2:    uword = '{MUL_NONE,     OP_RAMP, COND_NEXT,  4'd0, 1'b0};
            // speed * 1000 and angular * half wheelbase
            4'd3:    uword = '{MUL_V_K,      OP_NOP,  COND_NEXT,  4'd0, 1'b0};
            4'd4:    uword = '{MUL_ANG_HW,   OP_VK,   COND_NEXT,  4'd0, 1'b0};
            4'd5:    uword = '{MUL_NONE,     OP_AH,   COND_NEXT,  4'd0, 1'b0};
            // per-wheel loop: left pass, then right pass
            4'd6:    uword = '{MUL_NONE,     OP_SIDE, COND_NEXT,  4'd0, 1'b0};
            4'd7:    uword = '{MUL_MAG_GAIN, OP_NOP,  COND_NEXT,  4'd0, 1'b0};
            4'd8:    uword = '{MUL_NONE,     OP_X,    COND_NEXT,  4'd0, 1'b0};
            4'd9:    uword = '{MUL_X_RECIP,  OP_NOP,  COND_NEXT,  4'd0, 1'b0};
            4'd10:   uword = '{MUL_NONE,     OP_QE,   COND_NEXT,  4'd0, 1'b0};
            4'd11:   uword = '{MUL_Q_K,      OP_NOP,  COND_NEXT,  4'd0, 1'b0};
            4'd12:   uword = '{MUL_NONE,     OP_FIX,  COND_SIDE0, 4'd6, 1'b0};
            4'd13:   uword = '{MUL_NONE,     OP_NOP,  COND_NEXT,  4'd0, 1'b1};
            default: uword = '{MUL_NONE,     OP_NOP,  COND_NEXT,  4'd0, 1'b1};
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/srdd_sequencer.sv
// Step counter and jump logic for the microcode program.
// Depends on srdd_pkg.
`default_nettype none

module srdd_sequencer
    import srdd_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         stall,
    input  wire uword_t     uword,
    input  wire dp_status_t status,
    output pc_t         pc,
    output logic        busy
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic busy_reg;
    logic busy_next;
    logic take_jump;

    assign take_jump = (uword.cond == COND_SIDE0) && !status.side;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end
        else if (!stall)
        begin
            if (uword.last)
                busy_next = 1'b0;
            else if (take_jump)
                pc_next = uword.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign pc   = pc_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> hdl/srdd_datapath.sv
// Datapath: configuration registers, ramp state, shared multiplier and the
// operations the microcode steps select. Depends on srdd_pkg.
`default_nettype none

module srdd_datapath
    import srdd_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire cfg_index_t         cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data,
    input  wire                     load,
    input  wire [31:0]              now_ms,
    input  wire signed [12:0]       linear_target,
    input  wire signed [15:0]       angular_target,
    input  wire                     use_ramp,
    input  wire [14:0]              speed_factor,
    input  wire uword_t             uword,
    output dp_status_t              status,
    output logic signed [13:0]      ramped_speed,
    output logic signed [18:0]      left_rpm,
    output logic signed [18:0]      right_rpm
);

    // configuration
    logic        ramp_en_reg;
    logic [9:0]  accel_reg;
    logic [9:0]  decel_reg;
    logic [9:0]  hw_reg;
    logic [17:0] gain_reg;
    logic [7:0]  period_reg;

    // request fields
    logic [31:0]        now_reg;
    logic signed [12:0] lin_reg;
    logic signed [15:0] ang_reg;
    logic               use_reg;
    logic [14:0]        fac_reg;

    // state and work registers
    logic signed [13:0]       v_reg;
    logic signed [13:0]       v_next;
    logic [31:0]              nst_reg;
    logic [31:0]              nst_next;
    logic signed [13:0]       tgt_reg;
    logic signed [13:0]       tgt_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [23:0]       vk_reg;
    logic signed [25:0]       ah_reg;
    logic [26:0]              mag_reg;
    logic                     neg_reg;
    logic [27:0]              x_reg;
    logic [18:0]              q_reg;
    logic                     side_reg;
    logic signed [18:0]       left_reg;
    logic signed [18:0]       right_reg;
    logic signed [18:0]       rpm_next;

    // multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;

    // target rounding
    logic signed [27:0] t_prod;
    logic               t_neg;
    logic [27:0]        t_mag;
    logic [27:0]        t_sum;
    logic [13:0]        t_q;

    // ramp step
    logic               ramp_active;
    logic               step_due;
    logic [31:0]        due_diff;
    logic signed [15:0] v16;
    logic signed [15:0] t16;
    logic signed [15:0] acc16;
    logic signed [15:0] dec16;
    logic signed [15:0] vn;
    logic signed [15:0] vn_abs;
    logic signed [13:0] vn_sat;

    // wheel speed and rpm
    logic signed [26:0] s_wheel;
    logic [44:0]        x_sum;
    logic [28:0]        fix_r;
    logic [19:0]        q_fix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_en_reg <= RST_RAMP_ENABLE;
            accel_reg   <= RST_ACCEL_STEP;
            decel_reg   <= RST_DECEL_STEP;
            hw_reg      <= RST_HALF_WB;
            gain_reg    <= RST_RPM_GAIN;
            period_reg  <= RST_RAMP_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAMP_ENABLE: ramp_en_reg <= cfg_data[0];
                REG_ACCEL_STEP:  accel_reg   <= cfg_data[9:0];
                REG_DECEL_STEP:  decel_reg   <= cfg_data[9:0];
                REG_HALF_WB:     hw_reg      <= cfg_data[9:0];
                REG_RPM_GAIN:    gain_reg    <= cfg_data[17:0];
                REG_RAMP_PERIOD: period_reg  <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uword.mul)
            MUL_LIN_FAC:
            begin
                mul_a = MUL_A_W'(lin_reg);
                mul_b = MUL_B_W'(fac_reg);
            end
            MUL_V_K:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = K_MILLI;
            end
            MUL_ANG_HW:
            begin
                mul_a = MUL_A_W'(ang_reg);
                mul_b = MUL_B_W'(hw_reg);
            end
            MUL_MAG_GAIN:
            begin
                mul_a = $signed(MUL_A_W'(mag_reg));
                mul_b = MUL_B_W'(gain_reg);
            end
            MUL_X_RECIP:
            begin
                mul_a = $signed(MUL_A_W'(x_reg));
                mul_b = K_RECIP;
            end
            MUL_Q_K:
            begin
                mul_a = $signed(MUL_A_W'(q_reg));
                mul_b = K_MILLI;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * $signed({1'b0, mul_b});
    end

    // target: round half away from zero of lin * fac / 2^14
    always_comb
    begin
        t_prod = prod_reg[27:0];
        t_neg  = t_prod[27];
        t_mag  = t_neg ? 28'(-t_prod) : 28'(t_prod);
        t_sum  = t_mag + TGT_HALF;
        t_q    = t_sum[27:14];
        if (t_neg)
            tgt_next = (t_q > 14'd8192) ? SPEED_MIN : 14'(-$signed({1'b0, t_q}));
        else
            tgt_next = (t_q > 14'd8191) ? SPEED_MAX : $signed(t_q);
    end

    // ramp step
    always_comb
    begin
        ramp_active = ramp_en_reg && use_reg;
        due_diff    = now_reg - nst_reg;
        step_due    = !due_diff[31];
        v16         = 16'(v_reg);
        t16         = 16'(tgt_reg);
        acc16       = $signed({6'd0, accel_reg});
        dec16       = $signed({6'd0, decel_reg});
        if (t16 > 16'sd0)
        begin
            if (v16 < 16'sd0)
                vn = v16 + dec16;
            else if (v16 < t16)
                vn = v16 + acc16;
            else
                vn = v16 - dec16;
        end
        else if (t16 < 16'sd0)
        begin
            if (v16 > 16'sd0)
                vn = v16 - dec16;
            else if (v16 < t16)
                vn = v16 + dec16;
            else
                vn = v16 - acc16;
        end
        else
        begin
            vn = (v16 > 16'sd0) ? (v16 - dec16) : (v16 + dec16);
            // snap to rest inside one decel step
            vn_abs = (vn < 16'sd0) ? -vn : vn;
            if (vn != 16'sd0 && vn_abs < dec16)
                vn = 16'sd0;
        end
        vn_abs = (vn < 16'sd0) ? -vn : vn;
        if (vn > 16'sd8191)
            vn_sat = SPEED_MAX;
        else if (vn < -16'sd8192)
            vn_sat = SPEED_MIN;
        else
            vn_sat = vn[13:0];

        v_next   = v_reg;
        nst_next = nst_reg;
        if (!ramp_active)
            v_next = tgt_reg;
        else if (step_due)
        begin
            v_next   = vn_sat;
            nst_next = now_reg + 32'(period_reg);
        end
    end

    // wheel rpm: divide by 1000 * 65536, by 65536 as a shift, then by 1000 as a reciprocal multiply
    always_comb
    begin
        s_wheel = side_reg ? (27'(vk_reg) + 27'(ah_reg)) : (27'(vk_reg) - 27'(ah_reg));
        x_sum   = prod_reg[44:0] + RPM_HALF;
        fix_r   = {1'b0, x_reg} - prod_reg[28:0];
        q_fix   = 20'(q_reg) + ((fix_r >= K_THOUS29) ? 20'd1 : 20'd0);
        if (neg_reg)
            rpm_next = (q_fix > 20'd262144) ? RPM_MIN : 19'(-$signed(q_fix));
        else
            rpm_next = (q_fix > 20'd262143) ? RPM_MAX : $signed(q_fix[18:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            nst_reg  <= '0;
            side_reg <= 1'b0;
        end
        else
        begin
            if (uword.op == OP_RAMP)
            begin
                v_reg   <= v_next;
                nst_reg <= nst_next;
            end
            if (uword.op == OP_AH)
                side_reg <= 1'b0;
            else if (uword.op == OP_FIX)
                side_reg <= !side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            now_reg <= now_ms;
            lin_reg <= linear_target;
            ang_reg <= angular_target;
            use_reg <= use_ramp;
            fac_reg <= speed_factor;
        end
        if (uword.mul != MUL_NONE)
            prod_reg <= prod_next;
        unique case (uword.op)
            OP_TGT:  tgt_reg <= tgt_next;
            OP_VK:   vk_reg  <= prod_reg[23:0];
            OP_AH:   ah_reg  <= prod_reg[25:0];
            OP_SIDE:
            begin
                neg_reg <= s_wheel[26];
                mag_reg <= s_wheel[26] ? 27'(-s_wheel) : 27'(s_wheel);
            end
            OP_X:    x_reg <= x_sum[43:16];
            OP_QE:   q_reg <= prod_reg[50:32];
            OP_FIX:
            begin
                if (side_reg)
                    right_reg <= rpm_next;
                else
                    left_reg <= rpm_next;
            end
            default: ;
        endcase
    end

    assign status.side  = side_reg;
    assign ramped_speed = v_reg;
    assign left_rpm     = left_reg;
    assign right_rpm    = right_reg;

endmodule

`default_nettype wire
